>>> src/ahcp_pkg.sv
`default_nettype none

package ahcp_pkg;

    // result kinds
    typedef enum logic [2:0] {
        KIND_SEND   = 3'd0,
        KIND_FILTER = 3'd1,
        KIND_DELETE = 3'd2,
        KIND_LIST   = 3'd3,
        KIND_HELP   = 3'd4,
        KIND_ERROR  = 3'd5
    } t_kind;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_RTR        = 3'd1,
        ERR_HEX        = 3'd2,
        ERR_RANGE      = 3'd3,
        ERR_DECIMAL    = 3'd4,
        ERR_FILTER_NUM = 3'd5,
        ERR_COMMAND    = 3'd6
    } t_err;

    // identifier limits for standard and extended frames
    localparam logic [31:0] EXT_LIMIT = 32'h1fff_ffff;
    localparam logic [31:0] STD_LIMIT = 32'h0000_07ff;

    // one decoded command result
    typedef struct packed {
        t_kind       kind;
        logic        is_extended;
        logic        is_remote;
        logic        has_mask;
        logic [1:0]  remote_match;
        logic [28:0] ident;
        logic [28:0] id_mask;
        logic [3:0]  length_code;
        logic [63:0] payload;
        logic [6:0]  filter_index;
        t_err        error_code;
    } t_result;

endpackage

`default_nettype wire

>>> src/ahcp_rx_if.sv
`default_nettype none

interface ahcp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> src/ahcp_res_if.sv
`default_nettype none

interface ahcp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic        is_extended;
    logic        is_remote;
    logic        has_mask;
    logic [1:0]  remote_match;
    logic [28:0] ident;
    logic [28:0] id_mask;
    logic [3:0]  length_code;
    logic [63:0] payload;
    logic [6:0]  filter_index;
    logic [2:0]  error_code;

    modport source (
        output valid, input ready,
        output kind, output is_extended, output is_remote, output has_mask,
        output remote_match, output ident, output id_mask, output length_code,
        output payload, output filter_index, output error_code
    );
    modport sink (
        input valid, output ready,
        input kind, input is_extended, input is_remote, input has_mask,
        input remote_match, input ident, input id_mask, input length_code,
        input payload, input filter_index, input error_code
    );
endinterface

`default_nettype wire

>>> src/ascii_hex_can_command_parser.sv
// output: a result is registered and shown in the cycle after the byte that completes or fails its command
// throughput: one byte per cycle; the single output register stalls input only while
//   a held result is not taken
// reset: synchronous active-low i_rst_n returns the parser to idle with all
//   accumulators cleared and drops output valid
`default_nettype none

module ascii_hex_can_command_parser #(
    parameter int unsigned FILTER_BANKS = 14
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ahcp_rx_if.sink    i_rx,
    ahcp_res_if.source o_res
);

    // filter numbers at or above this are rejected
    localparam logic [6:0] FilterLimit = 7'(4 * FILTER_BANKS);

    // command and digit characters
    localparam logic [7:0] CH_DASH     = 8'h2d;
    localparam logic [7:0] CH_EQUAL    = 8'h3d;
    localparam logic [7:0] CH_UNDER    = 8'h5f;
    localparam logic [7:0] CH_PLUS     = 8'h2b;
    localparam logic [7:0] CH_COMMA    = 8'h2c;
    localparam logic [7:0] CH_DOT      = 8'h2e;
    localparam logic [7:0] CH_LESS     = 8'h3c;
    localparam logic [7:0] CH_GREATER  = 8'h3e;
    localparam logic [7:0] CH_SLASH    = 8'h2f;
    localparam logic [7:0] CH_QUESTION = 8'h3f;
    localparam logic [7:0] CH_UPPER_H  = 8'h48;
    localparam logic [7:0] CH_LOWER_H  = 8'h68;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_F  = 8'h46;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;

    typedef enum logic [8:0] {
        PH_IDLE    = 9'b0_0000_0001,
        PH_FR_DLC  = 9'b0_0000_0010,
        PH_FR_ID   = 9'b0_0000_0100,
        PH_FR_DATA = 9'b0_0000_1000,
        PH_FI_RTR  = 9'b0_0001_0000,
        PH_FI_ID   = 9'b0_0010_0000,
        PH_FI_MASK = 9'b0_0100_0000,
        PH_DEL_HI  = 9'b0_1000_0000,
        PH_DEL_LO  = 9'b1_0000_0000
    } t_phase;

    // hex digit decode, bit 4 set when not a hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] v;
        logic [7:0] d;
        begin
            v = 5'h10;
            d = 8'h00;
            if (c inside {[CH_ZERO:CH_NINE]}) begin
                d = c - CH_ZERO;
                v = {1'b0, d[3:0]};
            end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
                d = c - CH_UPPER_A + 8'd10;
                v = {1'b0, d[3:0]};
            end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
                d = c - CH_LOWER_A + 8'd10;
                v = {1'b0, d[3:0]};
            end
            return v;
        end
    endfunction

    t_phase      r_phase, n_phase;
    logic        r_ext, n_ext;
    logic        r_alt, n_alt;
    logic [4:0]  r_count, n_count;
    logic [31:0] r_id, n_id;
    logic [31:0] r_mask, n_mask;
    logic [63:0] r_data, n_data;
    logic [3:0]  r_len, n_len;
    logic [1:0]  r_rule, n_rule;
    logic [6:0]  r_del, n_del;

    logic                 r_out_valid;
    ahcp_pkg::t_result    r_res;
    ahcp_pkg::t_result    s_res;

    logic                 s_fire;
    logic                 s_emit;
    ahcp_pkg::t_kind      s_kind;
    ahcp_pkg::t_err       s_err;
    logic [4:0]           s_hex;
    logic                 s_bad;
    logic [3:0]           s_nib;
    logic [4:0]           s_count_inc;
    logic [4:0]           s_digits;
    logic [3:0]           s_bytes;
    logic [31:0]          s_acc_id;
    logic [31:0]          s_acc_mask;
    logic [31:0]          s_limit;
    logic [6:0]           s_del_sum;
    logic [3:0]           s_slot;
    logic [63:0]          s_data_ins;

    // handshake: take a byte unless a result is held and not taken
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign s_fire     = i_rx.valid && i_rx.ready;

    // shared decode of the incoming byte
    assign s_hex       = hex_decode(i_rx.rx_byte);
    assign s_bad       = s_hex[4];
    assign s_nib       = s_hex[3:0];
    assign s_count_inc = r_count + 5'd1;
    assign s_digits    = r_ext ? 5'd8 : 5'd3;
    assign s_bytes     = (r_len > 4'd8) ? 4'd8 : r_len;
    assign s_acc_id    = {r_id[27:0], s_nib};
    assign s_acc_mask  = {r_mask[27:0], s_nib};
    assign s_limit     = r_ext ? ahcp_pkg::EXT_LIMIT : ahcp_pkg::STD_LIMIT;
    assign s_del_sum   = r_del + {3'b000, s_nib};
    // nibble slot: byte index from count[3:1], high nibble first
    assign s_slot      = {r_count[3:1], ~r_count[0]};

    // data nibble insert
    always_comb begin
        s_data_ins = r_data;
        for (int k = 0; k < 16; k++) begin
            if (s_slot == 4'(k)) begin
                s_data_ins[4*k +: 4] = r_data[4*k +: 4] | s_nib;
            end
        end
    end

    // next parser state and result
    always_comb begin
        n_phase = r_phase;
        n_ext   = r_ext;
        n_alt   = r_alt;
        n_count = r_count;
        n_id    = r_id;
        n_mask  = r_mask;
        n_data  = r_data;
        n_len   = r_len;
        n_rule  = r_rule;
        n_del   = r_del;
        s_emit  = 1'b0;
        s_kind  = ahcp_pkg::KIND_SEND;
        s_err   = ahcp_pkg::ERR_NONE;

        case (r_phase)
            PH_IDLE: begin
                n_ext   = 1'b0;
                n_alt   = 1'b0;
                n_count = '0;
                n_id    = '0;
                n_mask  = '0;
                n_data  = '0;
                n_len   = '0;
                n_rule  = '0;
                n_del   = '0;
                case (i_rx.rx_byte)
                    CH_DASH: begin
                        n_phase = PH_FR_DLC;
                    end
                    CH_EQUAL: begin
                        n_ext   = 1'b1;
                        n_phase = PH_FR_DLC;
                    end
                    CH_UNDER: begin
                        n_alt   = 1'b1;
                        n_phase = PH_FR_DLC;
                    end
                    CH_PLUS: begin
                        n_ext   = 1'b1;
                        n_alt   = 1'b1;
                        n_phase = PH_FR_DLC;
                    end
                    CH_COMMA: begin
                        n_phase = PH_FI_RTR;
                    end
                    CH_DOT: begin
                        n_ext   = 1'b1;
                        n_phase = PH_FI_RTR;
                    end
                    CH_LESS: begin
                        n_alt   = 1'b1;
                        n_phase = PH_FI_RTR;
                    end
                    CH_GREATER: begin
                        n_ext   = 1'b1;
                        n_alt   = 1'b1;
                        n_phase = PH_FI_RTR;
                    end
                    CH_SLASH: begin
                        n_phase = PH_DEL_HI;
                    end
                    CH_QUESTION: begin
                        s_emit = 1'b1;
                        s_kind = ahcp_pkg::KIND_LIST;
                    end
                    CH_UPPER_H, CH_LOWER_H: begin
                        s_emit = 1'b1;
                        s_kind = ahcp_pkg::KIND_HELP;
                    end
                    default: begin
                        s_emit = 1'b1;
                        s_kind = ahcp_pkg::KIND_ERROR;
                        s_err  = ahcp_pkg::ERR_COMMAND;
                    end
                endcase
            end
            PH_FR_DLC: begin
                if (s_bad) begin
                    s_emit = 1'b1;
                    s_kind = ahcp_pkg::KIND_ERROR;
                    s_err  = ahcp_pkg::ERR_HEX;
                end else begin
                    n_len   = s_nib;
                    n_count = '0;
                    n_phase = PH_FR_ID;
                end
            end
            PH_FR_ID, PH_FI_ID: begin
                if (s_bad) begin
                    s_emit = 1'b1;
                    s_kind = ahcp_pkg::KIND_ERROR;
                    s_err  = ahcp_pkg::ERR_HEX;
                end else begin
                    n_id    = s_acc_id;
                    n_count = s_count_inc;
                    if (s_count_inc >= s_digits) begin
                        if (s_acc_id > s_limit) begin
                            s_emit = 1'b1;
                            s_kind = ahcp_pkg::KIND_ERROR;
                            s_err  = ahcp_pkg::ERR_RANGE;
                        end else begin
                            n_count = '0;
                            if (r_phase == PH_FI_ID) begin
                                if (r_alt) begin
                                    n_phase = PH_FI_MASK;
                                end else begin
                                    s_emit = 1'b1;
                                    s_kind = ahcp_pkg::KIND_FILTER;
                                end
                            end else if (r_alt || s_bytes == 4'd0) begin
                                s_emit = 1'b1;
                                s_kind = ahcp_pkg::KIND_SEND;
                            end else begin
                                n_phase = PH_FR_DATA;
                            end
                        end
                    end
                end
            end
            PH_FR_DATA: begin
                if (s_bad) begin
                    s_emit = 1'b1;
                    s_kind = ahcp_pkg::KIND_ERROR;
                    s_err  = ahcp_pkg::ERR_HEX;
                end else begin
                    n_data  = s_data_ins;
                    n_count = s_count_inc;
                    if (s_count_inc >= {s_bytes, 1'b0}) begin
                        s_emit = 1'b1;
                        s_kind = ahcp_pkg::KIND_SEND;
                    end
                end
            end
            PH_FI_RTR: begin
                if (s_bad || s_nib > 4'd3) begin
                    s_emit = 1'b1;
                    s_kind = ahcp_pkg::KIND_ERROR;
                    s_err  = ahcp_pkg::ERR_RTR;
                end else begin
                    n_rule  = (s_nib == 4'd2) ? 2'd1 : ((s_nib == 4'd3) ? 2'd2 : 2'd0);
                    n_id    = '0;
                    n_mask  = '0;
                    n_count = '0;
                    n_phase = PH_FI_ID;
                end
            end
            PH_FI_MASK: begin
                if (s_bad) begin
                    s_emit = 1'b1;
                    s_kind = ahcp_pkg::KIND_ERROR;
                    s_err  = ahcp_pkg::ERR_HEX;
                end else begin
                    n_mask  = s_acc_mask;
                    n_count = s_count_inc;
                    if (s_count_inc >= s_digits) begin
                        s_emit = 1'b1;
                        if (s_acc_mask > s_limit) begin
                            s_kind = ahcp_pkg::KIND_ERROR;
                            s_err  = ahcp_pkg::ERR_RANGE;
                        end else begin
                            s_kind = ahcp_pkg::KIND_FILTER;
                        end
                    end
                end
            end
            PH_DEL_HI: begin
                if (s_bad || s_nib > 4'd9) begin
                    s_emit = 1'b1;
                    s_kind = ahcp_pkg::KIND_ERROR;
                    s_err  = ahcp_pkg::ERR_DECIMAL;
                end else begin
                    // times ten as eight plus two
                    n_del   = {s_nib, 3'b000} + {2'b00, s_nib, 1'b0};
                    n_phase = PH_DEL_LO;
                end
            end
            PH_DEL_LO: begin
                if (s_bad || s_nib > 4'd9) begin
                    s_emit = 1'b1;
                    s_kind = ahcp_pkg::KIND_ERROR;
                    s_err  = ahcp_pkg::ERR_DECIMAL;
                end else begin
                    n_del  = s_del_sum;
                    s_emit = 1'b1;
                    if (s_del_sum >= FilterLimit) begin
                        s_kind = ahcp_pkg::KIND_ERROR;
                        s_err  = ahcp_pkg::ERR_FILTER_NUM;
                    end else begin
                        s_kind = ahcp_pkg::KIND_DELETE;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // result fields from the updated work registers
        s_res            = '0;
        s_res.kind       = s_kind;
        s_res.error_code = ahcp_pkg::ERR_NONE;
        case (s_kind)
            ahcp_pkg::KIND_SEND: begin
                s_res.is_extended = n_ext;
                s_res.is_remote   = n_alt;
                s_res.ident       = n_id[28:0];
                s_res.length_code = n_len;
                s_res.payload     = n_data;
            end
            ahcp_pkg::KIND_FILTER: begin
                s_res.is_extended  = n_ext;
                s_res.has_mask     = n_alt;
                s_res.remote_match = n_rule;
                s_res.ident        = n_id[28:0];
                s_res.id_mask      = n_alt ? n_mask[28:0] : 29'd0;
            end
            ahcp_pkg::KIND_DELETE: begin
                s_res.filter_index = n_del;
            end
            ahcp_pkg::KIND_ERROR: begin
                s_res.error_code = s_err;
            end
            default: begin
            end
        endcase

        // any result ends the command
        if (s_emit) begin
            n_phase = PH_IDLE;
            n_ext   = 1'b0;
            n_alt   = 1'b0;
            n_count = '0;
            n_id    = '0;
            n_mask  = '0;
            n_data  = '0;
            n_len   = '0;
            n_rule  = '0;
            n_del   = '0;
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ext   <= 1'b0;
            r_alt   <= 1'b0;
            r_count <= '0;
            r_id    <= '0;
            r_mask  <= '0;
            r_data  <= '0;
            r_len   <= '0;
            r_rule  <= '0;
            r_del   <= '0;
        end else if (s_fire) begin
            r_phase <= n_phase;
            r_ext   <= n_ext;
            r_alt   <= n_alt;
            r_count <= n_count;
            r_id    <= n_id;
            r_mask  <= n_mask;
            r_data  <= n_data;
            r_len   <= n_len;
            r_rule  <= n_rule;
            r_del   <= n_del;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire && s_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (s_fire && s_emit) begin
            r_res <= s_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_res.kind;
    assign o_res.is_extended  = r_res.is_extended;
    assign o_res.is_remote    = r_res.is_remote;
    assign o_res.has_mask     = r_res.has_mask;
    assign o_res.remote_match = r_res.remote_match;
    assign o_res.ident        = r_res.ident;
    assign o_res.id_mask      = r_res.id_mask;
    assign o_res.length_code  = r_res.length_code;
    assign o_res.payload      = r_res.payload;
    assign o_res.filter_index = r_res.filter_index;
    assign o_res.error_code   = r_res.error_code;

endmodule

`default_nettype wire

>>> src/ahcp_checker.sv
`default_nettype none

module ahcp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [2:0]  i_kind,
    input wire [2:0]  i_error_code,
    input wire [6:0]  i_filter_index
);

    // no result survives reset
    assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_error_code))
        else $error("stalled result changed");

    // empty output never blocks a request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // error code present exactly on error results
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_kind == ahcp_pkg::KIND_ERROR) == (i_error_code != 3'd0)))
        else $error("error code does not match kind");

    // delete results carry a two-digit filter number
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == ahcp_pkg::KIND_DELETE |-> i_filter_index <= 7'd99)
        else $error("filter number out of range");

endmodule

bind ascii_hex_can_command_parser ahcp_checker u_ahcp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_rx.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_kind         (o_res.kind),
    .i_error_code   (o_res.error_code),
    .i_filter_index (o_res.filter_index)
);

`default_nettype wire

>>> verif/ascii_hex_can_command_parser_tb.sv
`timescale 1ns / 1ps

module ascii_hex_can_command_parser_tb;

    localparam int unsigned FILTER_BANKS = 14;
    localparam int unsigned RANDOM_BYTES = 570;

    // parser phases tracked by the predictor
    typedef enum logic [3:0] {
        ST_IDLE, ST_FR_DLC, ST_FR_ID, ST_FR_DATA, ST_FI_RTR,
        ST_FI_ID, ST_FI_MASK, ST_DEL_HI, ST_DEL_LO
    } t_parse_state;

    // predicts decoded commands and checks them against the block
    class t_command_scoreboard;
        ahcp_pkg::t_result expected_results[$];
        int unsigned  mismatches;
        t_parse_state state;
        logic         is_ext;
        logic         alt_flag;
        logic [4:0]   ndig;
        logic [31:0]  id_acc;
        logic [31:0]  mask_acc;
        logic [63:0]  data_acc;
        logic [3:0]   dlc;
        logic [1:0]   rtr_rule;
        logic [6:0]   del_num;

        function new();
            mismatches = 0;
            clear_work();
        endfunction

        function void clear_work();
            state    = ST_IDLE;
            is_ext   = 1'b0;
            alt_flag = 1'b0;
            ndig     = '0;
            id_acc   = '0;
            mask_acc = '0;
            data_acc = '0;
            dlc      = '0;
            rtr_rule = '0;
            del_num  = '0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // 0..15 for a hex digit, 16 for anything else
        function logic [4:0] hex_nibble(logic [7:0] c);
            if (c >= "0" && c <= "9") return 5'(c - "0");
            if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
            if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
            return 5'd16;
        endfunction

        function int id_len();
            return is_ext ? 8 : 3;
        endfunction

        function bit in_range(logic [31:0] x);
            return x <= (is_ext ? ahcp_pkg::EXT_LIMIT : ahcp_pkg::STD_LIMIT);
        endfunction

        function int byte_count();
            return (dlc > 4'd8) ? 8 : int'(dlc);
        endfunction

        function void push_result(ahcp_pkg::t_result r);
            expected_results.push_back(r);
            clear_work();
        endfunction

        function void push_error(ahcp_pkg::t_err code);
            ahcp_pkg::t_result r;
            r = '0;
            r.kind = ahcp_pkg::KIND_ERROR;
            r.error_code = code;
            push_result(r);
        endfunction

        function void push_simple(ahcp_pkg::t_kind kind, logic [6:0] index);
            ahcp_pkg::t_result r;
            r = '0;
            r.kind = kind;
            r.filter_index = index;
            push_result(r);
        endfunction

        function void push_frame();
            ahcp_pkg::t_result r;
            r = '0;
            r.kind = ahcp_pkg::KIND_SEND;
            r.is_extended = is_ext;
            r.is_remote = alt_flag;
            r.ident = id_acc[28:0];
            r.length_code = dlc;
            r.payload = data_acc;
            push_result(r);
        endfunction

        function void push_filter();
            ahcp_pkg::t_result r;
            r = '0;
            r.kind = ahcp_pkg::KIND_FILTER;
            r.is_extended = is_ext;
            r.has_mask = alt_flag;
            r.remote_match = rtr_rule;
            r.ident = id_acc[28:0];
            r.id_mask = alt_flag ? mask_acc[28:0] : 29'd0;
            push_result(r);
        endfunction

        // lead character picks the command
        function void start_command(logic [7:0] c);
            clear_work();
            case (c)
                "-": state = ST_FR_DLC;
                "=": begin is_ext = 1'b1; state = ST_FR_DLC; end
                "_": begin alt_flag = 1'b1; state = ST_FR_DLC; end
                "+": begin is_ext = 1'b1; alt_flag = 1'b1; state = ST_FR_DLC; end
                ",": state = ST_FI_RTR;
                ".": begin is_ext = 1'b1; state = ST_FI_RTR; end
                "<": begin alt_flag = 1'b1; state = ST_FI_RTR; end
                ">": begin is_ext = 1'b1; alt_flag = 1'b1; state = ST_FI_RTR; end
                "/": state = ST_DEL_HI;
                "?": push_simple(ahcp_pkg::KIND_LIST, 7'd0);
                "H", "h": push_simple(ahcp_pkg::KIND_HELP, 7'd0);
                default: push_error(ahcp_pkg::ERR_COMMAND);
            endcase
        endfunction

        // advance the predicted parser by one accepted request
        function void note_byte(logic [7:0] c);
            logic [4:0] nib;
            logic [6:0] shift;
            nib = hex_nibble(c);
            case (state)
                ST_FR_DLC: begin
                    if (nib > 5'd15) push_error(ahcp_pkg::ERR_HEX);
                    else begin
                        dlc = nib[3:0];
                        ndig = '0;
                        state = ST_FR_ID;
                    end
                end
                ST_FR_ID, ST_FI_ID: begin
                    if (nib > 5'd15) push_error(ahcp_pkg::ERR_HEX);
                    else begin
                        id_acc = {id_acc[27:0], nib[3:0]};
                        ndig++;
                        if (ndig == id_len()) begin
                            if (!in_range(id_acc)) push_error(ahcp_pkg::ERR_RANGE);
                            else begin
                                ndig = '0;
                                if (state == ST_FI_ID) begin
                                    if (alt_flag) state = ST_FI_MASK;
                                    else push_filter();
                                end else if (alt_flag || byte_count() == 0) begin
                                    push_frame();
                                end else begin
                                    state = ST_FR_DATA;
                                end
                            end
                        end
                    end
                end
                ST_FR_DATA: begin
                    if (nib > 5'd15) push_error(ahcp_pkg::ERR_HEX);
                    else begin
                        // high nibble first within each byte, first byte lowest
                        shift = {ndig[4:1], 3'b000} + (ndig[0] ? 7'd0 : 7'd4);
                        data_acc = data_acc | (64'(nib[3:0]) << shift);
                        ndig++;
                        if (ndig == 2 * byte_count()) push_frame();
                    end
                end
                ST_FI_RTR: begin
                    if (nib > 5'd3) push_error(ahcp_pkg::ERR_RTR);
                    else begin
                        rtr_rule = (nib == 5'd2) ? 2'd1 : ((nib == 5'd3) ? 2'd2 : 2'd0);
                        id_acc = '0;
                        mask_acc = '0;
                        ndig = '0;
                        state = ST_FI_ID;
                    end
                end
                ST_FI_MASK: begin
                    if (nib > 5'd15) push_error(ahcp_pkg::ERR_HEX);
                    else begin
                        mask_acc = {mask_acc[27:0], nib[3:0]};
                        ndig++;
                        if (ndig == id_len()) begin
                            if (!in_range(mask_acc)) push_error(ahcp_pkg::ERR_RANGE);
                            else push_filter();
                        end
                    end
                end
                ST_DEL_HI: begin
                    if (nib > 5'd9) push_error(ahcp_pkg::ERR_DECIMAL);
                    else begin
                        del_num = 7'(nib * 10);
                        state = ST_DEL_LO;
                    end
                end
                ST_DEL_LO: begin
                    if (nib > 5'd9) push_error(ahcp_pkg::ERR_DECIMAL);
                    else begin
                        del_num = del_num + 7'(nib);
                        if (del_num >= 4 * FILTER_BANKS) push_error(ahcp_pkg::ERR_FILTER_NUM);
                        else push_simple(ahcp_pkg::KIND_DELETE, del_num);
                    end
                end
                default: start_command(c);
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
            if (got_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(ahcp_pkg::t_result got);
            ahcp_pkg::t_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual kind %0d error %0d",
                         $time, got.kind, got.error_code);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("is_extended", want.is_extended, got.is_extended);
            compare_field("is_remote", want.is_remote, got.is_remote);
            compare_field("has_mask", want.has_mask, got.has_mask);
            compare_field("remote_match", want.remote_match, got.remote_match);
            compare_field("ident", want.ident, got.ident);
            compare_field("id_mask", want.id_mask, got.id_mask);
            compare_field("length_code", want.length_code, got.length_code);
            compare_field("payload", want.payload, got.payload);
            compare_field("filter_index", want.filter_index, got.filter_index);
            compare_field("error_code", want.error_code, got.error_code);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   idle_pct = 35;

    t_command_scoreboard sb;
    logic [7:0] cmd_q[$];

    ahcp_rx_if  rx ();
    ahcp_res_if res ();

    ascii_hex_can_command_parser #(
        .FILTER_BANKS(FILTER_BANKS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx),
        .o_res  (res)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) res.ready <= 1'b0;
        else res.ready <= ($urandom_range(99) >= idle_pct);
    end

    // watch both channels
    always @(posedge i_clk) begin
        ahcp_pkg::t_result got;
        if (i_rst_n) begin
            if (res.valid && res.ready) begin
                got.kind         = ahcp_pkg::t_kind'(res.kind);
                got.is_extended  = res.is_extended;
                got.is_remote    = res.is_remote;
                got.has_mask     = res.has_mask;
                got.remote_match = res.remote_match;
                got.ident        = res.ident;
                got.id_mask      = res.id_mask;
                got.length_code  = res.length_code;
                got.payload      = res.payload;
                got.filter_index = res.filter_index;
                got.error_code   = ahcp_pkg::t_err'(res.error_code);
                sb.check_result(got);
            end
            if (rx.valid && rx.ready) sb.note_byte(rx.rx_byte);
        end
    end

    // one request, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            rx.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        do @(posedge i_clk); while (!rx.ready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_queue();
        foreach (cmd_q[i]) send_byte(cmd_q[i]);
    endtask

    // hold the sender until every predicted result has come out
    task automatic wait_drained();
        rx.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'("0" + n);
        if ($urandom_range(1)) return 8'("A" + n - 10);
        return 8'("a" + n - 10);
    endfunction

    function automatic void add_hex(input logic [31:0] value, input int n);
        for (int i = n - 1; i >= 0; i--) cmd_q.push_back(hex_char(value[4*i +: 4]));
    endfunction

    // mostly legal identifiers, with limits and out-of-range values mixed in
    function automatic logic [31:0] rand_ident(input bit ext);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) return ext ? 32'($urandom()) : 32'($urandom_range(4095));
        if (pick < 14) return ext ? ahcp_pkg::EXT_LIMIT : ahcp_pkg::STD_LIMIT;
        if (pick < 18) return 32'd0;
        return ext ? (32'($urandom()) & ahcp_pkg::EXT_LIMIT) : 32'($urandom_range(2047));
    endfunction

    // build one random command into cmd_q
    function automatic void build_random_command();
        int unsigned pick;
        int unsigned pos;
        logic [7:0]  lead;
        logic [3:0]  dlc;
        bit          ext;
        bit          alt;
        cmd_q.delete();
        pick = $urandom_range(99);
        if (pick < 40) begin
            // send frame
            case ($urandom_range(3))
                0: lead = "-";
                1: lead = "=";
                2: lead = "_";
                default: lead = "+";
            endcase
            ext = (lead == "=" || lead == "+");
            alt = (lead == "_" || lead == "+");
            dlc = ($urandom_range(99) < 80) ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
            cmd_q.push_back(lead);
            add_hex(dlc, 1);
            add_hex(rand_ident(ext), ext ? 8 : 3);
            if (!alt) begin
                for (int i = 0; i < ((dlc > 4'd8) ? 8 : int'(dlc)); i++) begin
                    add_hex($urandom_range(255), 2);
                end
            end
        end else if (pick < 70) begin
            // add filter
            case ($urandom_range(3))
                0: lead = ",";
                1: lead = ".";
                2: lead = "<";
                default: lead = ">";
            endcase
            ext = (lead == "." || lead == ">");
            alt = (lead == "<" || lead == ">");
            cmd_q.push_back(lead);
            if ($urandom_range(99) < 94) add_hex($urandom_range(3), 1);
            else add_hex($urandom_range(15, 4), 1);
            add_hex(rand_ident(ext), ext ? 8 : 3);
            if (alt) add_hex(rand_ident(ext), ext ? 8 : 3);
        end else if (pick < 80) begin
            // delete filter
            cmd_q.push_back("/");
            cmd_q.push_back(8'("0" + $urandom_range(9)));
            cmd_q.push_back(8'("0" + $urandom_range(9)));
        end else if (pick < 86) begin
            case ($urandom_range(2))
                0: cmd_q.push_back("?");
                1: cmd_q.push_back("H");
                default: cmd_q.push_back("h");
            endcase
        end else begin
            // line noise
            repeat ($urandom_range(3, 1)) cmd_q.push_back(8'($urandom_range(255)));
        end
        // broken sequence: one random byte, rest of the command dropped
        if (pick < 80 && $urandom_range(99) < 10) begin
            pos = $urandom_range(cmd_q.size() - 1, 1);
            cmd_q[pos] = 8'($urandom_range(255));
            cmd_q = cmd_q[0:pos];
        end
    endfunction

    task automatic directed_part();
        send_text("?");
        send_text("H");
        send_text("h");
        send_byte(8'h00);
        send_byte(8'hff);
        send_text("x");
        // frames: normal, long dlc with max ext id, empty, remote, range errors, bad hex digits
        send_text("-3123AbBc0D");
        send_text("=F1FFFFFFF0123456789abcdef");
        send_text("-0000");
        send_text("_87FF");
        send_text("+000000000");
        send_text("-0800");
        send_text("=0FFFFFFFF");
        send_text("-G");
        send_text("-112Z");
        send_text("-1123g");
        // filters: each form, bad rtr, bad mask digit, range errors
        send_text(",0123");
        send_text(".31abcdef0");
        send_text("<27FF7ff");
        send_text(">11FFFFFFF1fffffff");
        send_text("<1123800");
        send_text("<1FFF");
        send_text(",4");
        send_text(",x");
        send_text(">312345678123Z");
        // delete: limits of the filter number and bad digits
        send_text("/00");
        send_text("/55");
        send_text("/56");
        send_text("/99");
        send_text("/A");
        send_text("/5:");
    endtask

    task automatic random_part();
        int unsigned sent;
        int unsigned n;
        sent = 0;
        n = 0;
        while (sent < RANDOM_BYTES) begin
            // a stretch with no idling on either side
            if (n == 15) idle_pct = 0;
            if (n == 30) idle_pct = 35;
            if (n == 25 || n == 45) wait_drained();
            build_random_command();
            send_queue();
            sent += cmd_q.size();
            n++;
        end
    endtask

    // main sequence
    initial begin
        sb = new();
        rx.valid   = 1'b0;
        rx.rx_byte = '0;
        i_rst_n    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_part();
        wait_drained();
        random_part();
        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
src/ahcp_pkg.sv
src/ahcp_rx_if.sv
src/ahcp_res_if.sv
src/ascii_hex_can_command_parser.sv
src/ahcp_checker.sv
verif/ascii_hex_can_command_parser_tb.sv
